// File: rtl/mwbm_pkg.sv
// Shared types and constants for the MIDI wildcard binding matcher.
`timescale 1ns / 1ps

package mwbm_pkg;

    localparam int ACTION_W = 10;

    localparam logic [4:0] ANY_CHAN = 5'd16;
    localparam logic [7:0] ANY_DATA = 8'd128;
    localparam logic [7:0] MAX_DATA = 8'd127;
    localparam logic [3:0] TYPE_BASE = 4'd8;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_LOOKUP = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        RES_DONE  = 2'd0,
        RES_RANGE = 2'd1,
        RES_FULL  = 2'd2
    } res_code_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVAL
    } state_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [7:0]          status_byte;
        logic [3:0]          bind_type;
        logic [4:0]          bind_channel;
        logic [7:0]          first_data;
        logic [7:0]          second_data;
        logic [ACTION_W-1:0] action_code;
    } cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] matched_action;
        logic [1:0]          result_code;
    } res_t;

    typedef struct packed {
        logic [2:0] msg_type;
        logic [4:0] chan;
        logic [7:0] d1;
        logic [7:0] d2;
    } key_t;

    typedef struct packed {
        logic chan_hit;
        logic d1_hit;
        logic d1_any;
    } chan_flags_t;

endpackage

// File: rtl/midi_wildcard_binding_matcher.sv
// Top level of the MIDI wildcard binding matcher: binding table, scan engine and lookup resolve.
`timescale 1ns / 1ps

// Usage:
//   Command channel: drive cmd and raise start; the transfer happens at a rising edge
//   with start high and busy low. kind selects clear, insert or lookup.
//   Result channel: result_valid is high for exactly one cycle with result; the
//   transfer happens at the edge that ends that cycle. The receiver cannot stall.
// Command flow:
//   Insert and lookup scan every stored binding through the key/action memory read
//   port, one entry per cycle, then evaluate; result_valid is registered from the
//   evaluate state. Clear, rejected inserts, invalid lookups and the unused kind
//   skip the scan and go from the transfer straight to the evaluate state.
//   busy drops in the result cycle, so the next command can transfer at the edge that
//   ends it; no new command transfers while one is in progress.
// Reset:
//   rst_n clears the binding count and all control state; the table contents stay
//   undefined and are never read until written. No clearing pass is needed.

module midi_wildcard_binding_matcher
    import mwbm_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int ACTION_BITS   = 10
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  cmd_t cmd,
    output logic busy,
    output logic result_valid,
    output res_t result
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    state_t                 state_reg;
    state_t                 state_next;
    cmd_t                   cmd_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       addr_reg;
    logic                   rd_pend_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    key_t                   rd_key_reg;
    logic [ACTION_BITS-1:0] rd_act_reg;
    logic                   hit_reg;
    logic [IDX_W-1:0]       hit_idx_reg;
    chan_flags_t            flags_reg [2];
    logic [ACTION_BITS-1:0] vals_reg [2][4];
    logic                   result_valid_reg;
    res_t                   result_reg;

    key_t                   key_mem [TABLE_ENTRIES];
    logic [ACTION_BITS-1:0] act_mem [TABLE_ENTRIES];

    logic                   accept;
    logic                   rd_en;
    logic                   ins_eval;
    logic                   has_room;
    logic                   key_wr_en;
    logic                   act_wr_en;
    logic [IDX_W-1:0]       wr_idx;
    key_t                   ins_key;
    logic [2:0]             look_type;
    logic [4:0]             look_chan [2];
    res_code_t              res_code;
    logic                   cx;
    logic                   s1;
    logic [ACTION_BITS-1:0] first_act;
    logic [ACTION_BITS-1:0] lookup_act;

    function automatic logic in_range(input cmd_t c);
        return (c.bind_type >= TYPE_BASE) && (c.bind_channel <= ANY_CHAN)
            && (c.first_data <= ANY_DATA) && (c.second_data <= ANY_DATA);
    endfunction

    function automatic logic look_ok(input cmd_t c);
        return c.status_byte[7] && (c.first_data <= MAX_DATA) && (c.second_data <= MAX_DATA);
    endfunction

    function automatic logic [ACTION_BITS-1:0] pick(input logic [ACTION_BITS-1:0] a,
                                                    input logic [ACTION_BITS-1:0] b);
        return (a != '0) ? a : b;
    endfunction

    assign ins_key = '{msg_type: cmd_reg.bind_type[2:0], chan: cmd_reg.bind_channel,
                       d1: cmd_reg.first_data, d2: cmd_reg.second_data};
    assign look_type    = cmd_reg.status_byte[6:4];
    assign look_chan[0] = {1'b0, cmd_reg.status_byte[3:0]};
    assign look_chan[1] = ANY_CHAN;
    assign has_room     = count_reg < CNT_W'(TABLE_ENTRIES);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((cmd.kind == KIND_INSERT && in_range(cmd))
                        || (cmd.kind == KIND_LOOKUP && look_ok(cmd)))
                        state_next = ST_SCAN;
                    else
                        state_next = ST_EVAL;
                end
            end
            ST_SCAN:
            begin
                if (addr_reg == count_reg)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb
    begin
        busy      = (state_reg != ST_IDLE);
        accept    = start && !busy;
        rd_en     = (state_reg == ST_SCAN) && (addr_reg < count_reg);
        ins_eval  = (state_reg == ST_EVAL) && (cmd_reg.kind == KIND_INSERT) && in_range(cmd_reg);
        act_wr_en = ins_eval && (hit_reg || has_room);
        key_wr_en = ins_eval && !hit_reg && has_room;
        wr_idx    = hit_reg ? hit_idx_reg : count_reg[IDX_W-1:0];
        res_code  = RES_DONE;
        if (cmd_reg.kind == KIND_INSERT)
        begin
            if (!in_range(cmd_reg))
                res_code = RES_RANGE;
            else if (!hit_reg && !has_room)
                res_code = RES_FULL;
        end
    end

    // resolve: channel, then data1, then data2 with wildcard fallbacks
    always_comb
    begin
        cx         = !flags_reg[0].chan_hit;
        s1         = !flags_reg[cx].d1_hit;
        first_act  = pick(vals_reg[cx][{s1, 1'b0}], vals_reg[cx][{s1, 1'b1}]);
        lookup_act = '0;
        if (look_ok(cmd_reg) && (flags_reg[0].chan_hit || flags_reg[1].chan_hit)
            && (flags_reg[cx].d1_hit || flags_reg[cx].d1_any))
        begin
            if (first_act != '0)
                lookup_act = first_act;
            else if (flags_reg[cx].d1_any)
                lookup_act = pick(vals_reg[cx][2], vals_reg[cx][3]);
            else if (flags_reg[1].chan_hit)
            begin
                if (flags_reg[1].d1_hit)
                    lookup_act = pick(vals_reg[1][0], vals_reg[1][1]);
                else if (flags_reg[1].d1_any)
                    lookup_act = pick(vals_reg[1][2], vals_reg[1][3]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            addr_reg         <= '0;
            rd_pend_reg      <= 1'b0;
            hit_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rd_pend_reg      <= rd_en;
            result_valid_reg <= (state_reg == ST_EVAL);
            if (accept)
            begin
                addr_reg <= '0;
                hit_reg  <= 1'b0;
                if (cmd.kind == KIND_CLEAR)
                    count_reg <= '0;
            end
            else
            begin
                if (rd_en)
                    addr_reg <= addr_reg + 1'b1;
                if (rd_pend_reg && rd_key_reg == ins_key)
                    hit_reg <= 1'b1;
                if (key_wr_en)
                    count_reg <= count_reg + 1'b1;
            end
        end
    end

    // scan datapath: hold command, collect prefix and value matches
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_idx_reg <= addr_reg[IDX_W-1:0];
        if (accept)
        begin
            cmd_reg <= cmd;
            for (int x = 0; x < 2; x++)
            begin
                flags_reg[x] <= '0;
                for (int v = 0; v < 4; v++)
                    vals_reg[x][v] <= '0;
            end
        end
        else if (rd_pend_reg)
        begin
            if (rd_key_reg == ins_key)
                hit_idx_reg <= rd_idx_reg;
            for (int x = 0; x < 2; x++)
            begin
                if (rd_key_reg.msg_type == look_type && rd_key_reg.chan == look_chan[x])
                begin
                    flags_reg[x].chan_hit <= 1'b1;
                    if (rd_key_reg.d1 == cmd_reg.first_data)
                    begin
                        flags_reg[x].d1_hit <= 1'b1;
                        if (rd_key_reg.d2 == cmd_reg.second_data)
                            vals_reg[x][0] <= rd_act_reg;
                        if (rd_key_reg.d2 == ANY_DATA)
                            vals_reg[x][1] <= rd_act_reg;
                    end
                    if (rd_key_reg.d1 == ANY_DATA)
                    begin
                        flags_reg[x].d1_any <= 1'b1;
                        if (rd_key_reg.d2 == cmd_reg.second_data)
                            vals_reg[x][2] <= rd_act_reg;
                        if (rd_key_reg.d2 == ANY_DATA)
                            vals_reg[x][3] <= rd_act_reg;
                    end
                end
            end
        end
    end

    // binding table
    always_ff @(posedge clk)
    begin
        if (key_wr_en)
            key_mem[wr_idx] <= ins_key;
        if (act_wr_en)
            act_mem[wr_idx] <= ACTION_BITS'(cmd_reg.action_code);
        if (rd_en)
        begin
            rd_key_reg <= key_mem[addr_reg[IDX_W-1:0]];
            rd_act_reg <= act_mem[addr_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EVAL)
        begin
            result_reg.matched_action <= (cmd_reg.kind == KIND_LOOKUP)
                                       ? ACTION_W'(lookup_act) : '0;
            result_reg.result_code    <= res_code;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("binding count above table size");

    a_result_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_EVAL))
        else $error("result strobe without evaluation");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_reject_no_action: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.result_code != RES_DONE) |-> result.matched_action == '0)
        else $error("rejected insert reports an action");
`endif

endmodule

// File: sim/tb_top.sv
// Testbench for the MIDI wildcard binding matcher: directed and random commands against a table predictor.
`timescale 1ns / 1ps

module tb_top;
    import mwbm_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int TABLE_DEPTH = 64;

    class binding_checker;
        key_t                bound_key[TABLE_DEPTH];
        logic [ACTION_W-1:0] bound_action[TABLE_DEPTH];
        int                  bound_count;
        res_t                expected_results[$];
        int                  mismatches;

        function new();
            bound_count = 0;
            mismatches = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            mismatches++;
        endtask

        function bit has_prefix(logic [2:0] t, logic [4:0] c, logic [7:0] d1, bit with_d1);
            for (int i = 0; i < bound_count; i++)
            begin
                if (bound_key[i].msg_type == t && bound_key[i].chan == c &&
                    (!with_d1 || bound_key[i].d1 == d1))
                begin
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function logic [ACTION_W-1:0] action_at(logic [2:0] t, logic [4:0] c,
                                                logic [7:0] d1, logic [7:0] d2);
            for (int i = 0; i < bound_count; i++)
            begin
                if (bound_key[i] == {t, c, d1, d2})
                begin
                    return bound_action[i];
                end
            end
            return '0;
        endfunction

        function logic [ACTION_W-1:0] action_or_any(logic [2:0] t, logic [4:0] c,
                                                    logic [7:0] d1, logic [7:0] d2);
            logic [ACTION_W-1:0] r;
            r = action_at(t, c, d1, d2);
            if (r == '0)
            begin
                r = action_at(t, c, d1, ANY_DATA);
            end
            return r;
        endfunction

        function logic [ACTION_W-1:0] resolve_lookup(logic [7:0] status, logic [7:0] d1,
                                                     logic [7:0] d2);
            logic [2:0]          t;
            logic [4:0]          c;
            logic [7:0]          sel;
            logic [ACTION_W-1:0] r;
            if (status[7:4] < TYPE_BASE || d1 > MAX_DATA || d2 > MAX_DATA)
            begin
                return '0;
            end
            t = status[6:4];
            c = {1'b0, status[3:0]};
            if (!has_prefix(t, c, '0, 1'b0))
            begin
                c = ANY_CHAN;
                if (!has_prefix(t, c, '0, 1'b0))
                begin
                    return '0;
                end
            end
            if (has_prefix(t, c, d1, 1'b1))
                sel = d1;
            else if (has_prefix(t, c, ANY_DATA, 1'b1))
                sel = ANY_DATA;
            else
                return '0;
            r = action_or_any(t, c, sel, d2);
            if (r != '0)
            begin
                return r;
            end
            if (has_prefix(t, c, ANY_DATA, 1'b1))
            begin
                return action_or_any(t, c, ANY_DATA, d2);
            end
            c = ANY_CHAN;
            if (!has_prefix(t, c, '0, 1'b0))
            begin
                return '0;
            end
            if (has_prefix(t, c, d1, 1'b1))
                sel = d1;
            else if (has_prefix(t, c, ANY_DATA, 1'b1))
                sel = ANY_DATA;
            else
                return '0;
            return action_or_any(t, c, sel, d2);
        endfunction

        function res_code_t store_binding(cmd_t c);
            key_t k;
            if (c.bind_type < TYPE_BASE || c.bind_channel > ANY_CHAN ||
                c.first_data > ANY_DATA || c.second_data > ANY_DATA)
            begin
                return RES_RANGE;
            end
            k = {c.bind_type[2:0], c.bind_channel, c.first_data, c.second_data};
            for (int i = 0; i < bound_count; i++)
            begin
                if (bound_key[i] == k)
                begin
                    bound_action[i] = c.action_code;
                    return RES_DONE;
                end
            end
            if (bound_count >= TABLE_DEPTH)
            begin
                return RES_FULL;
            end
            bound_key[bound_count] = k;
            bound_action[bound_count] = c.action_code;
            bound_count++;
            return RES_DONE;
        endfunction

        function void note_command(cmd_t c);
            res_t r;
            r.matched_action = '0;
            r.result_code = RES_DONE;
            case (c.kind)
                KIND_CLEAR:  bound_count = 0;
                KIND_INSERT: r.result_code = store_binding(c);
                KIND_LOOKUP: r.matched_action = resolve_lookup(c.status_byte, c.first_data,
                                                               c.second_data);
                default: ;
            endcase
            expected_results.insert(expected_results.size(), r);
        endfunction

        task check_result(res_t got);
            res_t want;
            if (expected_results.size() == 0)
            begin
                report($sformatf("result %h with nothing outstanding", got));
                return;
            end
            want = expected_results.pop_front();
            if (got.matched_action !== want.matched_action)
            begin
                report($sformatf("matched_action %0d, expected %0d",
                                 got.matched_action, want.matched_action));
            end
            if (got.result_code !== want.result_code)
            begin
                report($sformatf("result_code %0d, expected %0d",
                                 got.result_code, want.result_code));
            end
        endtask

        task drain_check();
            if (expected_results.size() != 0)
            begin
                report($sformatf("%0d results never arrived", expected_results.size()));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    cmd_t cmd;
    logic busy;
    logic result_valid;
    res_t result;

    binding_checker bindings;
    int             issued;
    int             burst_left;
    int             episodes;
    cmd_t           inserted[$];
    logic [3:0]     type_pool[2];
    logic [4:0]     chan_pool[3];
    logic [7:0]     d1_pool[3];
    logic [7:0]     d2_pool[3];

    midi_wildcard_binding_matcher i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            bindings.check_result(result);
        end
    end

    function automatic cmd_t make_cmd(logic [1:0] kind, logic [7:0] status, logic [3:0] btype,
                                      logic [4:0] chan, logic [7:0] d1, logic [7:0] d2,
                                      logic [ACTION_W-1:0] act);
        cmd_t c;
        c.kind = kind;
        c.status_byte = status;
        c.bind_type = btype;
        c.bind_channel = chan;
        c.first_data = d1;
        c.second_data = d2;
        c.action_code = act;
        return c;
    endfunction

    function automatic cmd_t noise_cmd();
        return make_cmd(2'($urandom), 8'($urandom), 4'($urandom), 5'($urandom),
                        8'($urandom), 8'($urandom), ACTION_W'($urandom));
    endfunction

    function automatic cmd_t pooled_binding(bit wide);
        cmd_t c;
        c = noise_cmd();
        c.kind = KIND_INSERT;
        if (wide)
        begin
            c.bind_type = 4'($urandom_range(8, 15));
            c.bind_channel = 5'($urandom_range(0, 16));
            c.first_data = 8'($urandom_range(0, 128));
            c.second_data = 8'($urandom_range(0, 128));
        end
        else
        begin
            c.bind_type = type_pool[$urandom_range(0, 1)];
            c.bind_channel = chan_pool[$urandom_range(0, 2)];
            c.first_data = d1_pool[$urandom_range(0, 2)];
            c.second_data = d2_pool[$urandom_range(0, 2)];
        end
        if ($urandom_range(0, 9) == 0)
        begin
            c.action_code = '0;
        end
        return c;
    endfunction

    function automatic cmd_t lookup_from(cmd_t b);
        cmd_t c;
        c = noise_cmd();
        c.kind = KIND_LOOKUP;
        c.status_byte = {b.bind_type,
                         b.bind_channel == ANY_CHAN ? 4'($urandom) : b.bind_channel[3:0]};
        c.first_data = b.first_data == ANY_DATA ? 8'($urandom_range(0, 127)) : b.first_data;
        c.second_data = b.second_data == ANY_DATA ? 8'($urandom_range(0, 127)) : b.second_data;
        case ($urandom_range(0, 9))
            0: c.status_byte[3:0] = 4'($urandom);
            1: c.first_data = 8'($urandom_range(0, 127));
            2: c.second_data = 8'($urandom_range(0, 127));
            3: c.status_byte[7:4] = type_pool[$urandom_range(0, 1)];
            default: ;
        endcase
        return c;
    endfunction

    task automatic send(input cmd_t c);
        cmd <= c;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        bindings.note_command(c);
        issued++;
        if (c.kind == KIND_CLEAR)
            inserted.delete();
        else if (c.kind == KIND_INSERT)
            inserted.insert(inserted.size(), c);
        if (inserted.size() > 200)
            void'(inserted.pop_front());
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            start <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(20, 90)) @(posedge clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 5);
        end
    endtask

    task automatic send_lookup();
        if (inserted.size() == 0)
            send(make_cmd(KIND_LOOKUP, 8'($urandom), 4'($urandom), 5'($urandom),
                          8'($urandom_range(0, 127)), 8'($urandom_range(0, 127)),
                          ACTION_W'($urandom)));
        else
            send(lookup_from(inserted[$urandom_range(0, inserted.size() - 1)]));
    endtask

    task automatic run_episode(bit wide);
        int   n;
        cmd_t dup;
        type_pool[0] = 4'($urandom_range(8, 15));
        type_pool[1] = 4'($urandom_range(8, 15));
        chan_pool[0] = 5'($urandom_range(0, 15));
        chan_pool[1] = 5'($urandom_range(0, 15));
        chan_pool[2] = ANY_CHAN;
        d1_pool[0] = 8'($urandom_range(0, 127));
        d1_pool[1] = ($urandom_range(0, 3) == 0) ? MAX_DATA : 8'($urandom_range(0, 127));
        d1_pool[2] = ANY_DATA;
        d2_pool[0] = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 127));
        d2_pool[1] = 8'($urandom_range(0, 127));
        d2_pool[2] = ANY_DATA;
        if ($urandom_range(0, 4) != 0)
            send(make_cmd(KIND_CLEAR, 8'($urandom), 4'($urandom), 5'($urandom),
                          8'($urandom), 8'($urandom), ACTION_W'($urandom)));
        n = wide ? $urandom_range(66, 74) : $urandom_range(4, 12);
        repeat (n)
        begin
            if (!wide && $urandom_range(0, 4) == 0)
                send_lookup();
            if (wide && inserted.size() != 0 && $urandom_range(0, 7) == 0)
            begin
                dup = inserted[$urandom_range(0, inserted.size() - 1)];
                dup.action_code = ACTION_W'($urandom);
                send(dup);
            end
            else
            begin
                send(pooled_binding(wide));
            end
        end
        repeat ($urandom_range(15, 40))
        begin
            case ($urandom_range(0, 9))
                0: send(pooled_binding(wide));
                1: send(noise_cmd());
                default: send_lookup();
            endcase
        end
    endtask

    initial
    begin
        int waited;
        bindings = new();
        issued = 0;
        burst_left = 0;
        episodes = 0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(make_cmd(KIND_LOOKUP, 8'h90, 4'd0, 5'd0, 8'd60, 8'd100, 10'd0));
        send(make_cmd(KIND_INSERT, 8'h00, 4'd15, ANY_CHAN, ANY_DATA, ANY_DATA, 10'd1023));
        send(make_cmd(KIND_INSERT, 8'h00, 4'd8, 5'd0, 8'd0, 8'd0, 10'd1));
        send(make_cmd(KIND_INSERT, 8'h00, 4'd9, 5'd3, 8'd5, 8'd6, 10'd0));
        send(make_cmd(KIND_INSERT, 8'h00, 4'd9, ANY_CHAN, 8'd5, ANY_DATA, 10'd77));
        send(make_cmd(KIND_INSERT, 8'h00, 4'd7, 5'd0, 8'd0, 8'd0, 10'd5));
        send(make_cmd(KIND_INSERT, 8'h00, 4'd8, 5'd17, 8'd0, 8'd0, 10'd5));
        send(make_cmd(KIND_INSERT, 8'h00, 4'd8, 5'd0, 8'd129, 8'd0, 10'd5));
        send(make_cmd(KIND_INSERT, 8'h00, 4'd8, 5'd0, 8'd0, 8'd255, 10'd5));
        send(make_cmd(KIND_INSERT, 8'hFF, 4'd0, 5'd31, 8'd255, 8'd255, 10'd1023));
        send(make_cmd(KIND_INSERT, 8'h00, 4'd8, 5'd0, 8'd0, 8'd0, 10'd512));
        send(make_cmd(KIND_LOOKUP, 8'h80, 4'd0, 5'd0, 8'd0, 8'd0, 10'd0));
        send(make_cmd(KIND_LOOKUP, 8'hFF, 4'd0, 5'd0, 8'd127, 8'd127, 10'd0));
        send(make_cmd(KIND_LOOKUP, 8'h93, 4'd0, 5'd0, 8'd5, 8'd6, 10'd0));
        send(make_cmd(KIND_LOOKUP, 8'h9A, 4'd0, 5'd0, 8'd5, 8'd0, 10'd0));
        send(make_cmd(KIND_LOOKUP, 8'h7F, 4'd15, 5'd16, 8'd0, 8'd0, 10'd1023));
        send(make_cmd(KIND_LOOKUP, 8'h80, 4'd0, 5'd0, 8'd128, 8'd0, 10'd0));
        send(make_cmd(KIND_LOOKUP, 8'hF0, 4'd0, 5'd0, 8'd0, 8'd255, 10'd0));
        send(make_cmd(KIND_UNUSED, 8'hFF, 4'd15, 5'd31, 8'd255, 8'd255, 10'd1023));
        send(make_cmd(KIND_CLEAR, 8'h00, 4'd0, 5'd0, 8'd0, 8'd0, 10'd0));
        send(make_cmd(KIND_LOOKUP, 8'hFF, 4'd0, 5'd0, 8'd0, 8'd0, 10'd0));

        while (issued < 950)
        begin
            run_episode(episodes == 0 || $urandom_range(0, 4) == 0);
            episodes++;
        end

        start <= 1'b0;
        waited = 0;
        while (bindings.expected_results.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (80) @(posedge clk);
        bindings.drain_check();
        if (bindings.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
